@@ src/tmqm_pkg.sv @@
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package tmqm_pkg;
  localparam int SLOTS_DEFAULT  = 16;
  localparam int QUEUES_DEFAULT = 8;

  localparam logic [15:0] BYTE_LIMIT_RESET = 16'd2048;
  localparam logic [11:0] MAX_BYTES_RESET  = 12'd640;
  localparam int          BYTES_W          = 17;

  localparam logic [1:0] MODE_SEND   = 2'd0;
  localparam logic [1:0] MODE_RECV   = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;
  localparam logic [1:0] MODE_STATUS = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NO_SLOT  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;
  localparam logic [2:0] ST_TOO_BIG  = 3'd5;

  localparam logic CFG_BYTE_LIMIT = 1'b0;
  localparam logic CFG_MAX_BYTES  = 1'b1;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_QLATCH    = 4'd2;
  localparam logic [OP_W-1:0] OP_BAD       = 4'd3;
  localparam logic [OP_W-1:0] OP_SEND_CHK  = 4'd4;
  localparam logic [OP_W-1:0] OP_SEND_RD   = 4'd5;
  localparam logic [OP_W-1:0] OP_SEND_WR   = 4'd6;
  localparam logic [OP_W-1:0] OP_SEND_TAIL = 4'd7;
  localparam logic [OP_W-1:0] OP_WALK_INIT = 4'd8;
  localparam logic [OP_W-1:0] OP_WALK_RD   = 4'd9;
  localparam logic [OP_W-1:0] OP_R_EVAL    = 4'd10;
  localparam logic [OP_W-1:0] OP_R_FIN     = 4'd11;
  localparam logic [OP_W-1:0] OP_R_PUSH    = 4'd12;
  localparam logic [OP_W-1:0] OP_F_EVAL    = 4'd13;
  localparam logic [OP_W-1:0] OP_F_FIN     = 4'd14;
  localparam logic [OP_W-1:0] OP_RESP      = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       q_bad;
    logic       send_ok;
    logic       walk_more;
    logic       recv_ok;
    logic       out_free;
  } stat_t;
endpackage
`default_nettype wire

@@ src/tmqm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tmqm_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic         clk,
  input  wire logic         we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [W-1:0]      rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/tmqm_ctrl.sv @@
// Controller: sequences each request through datapath operations.
`timescale 1ns / 1ps
`default_nettype none
module tmqm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire tmqm_pkg::stat_t st,
  output tmqm_pkg::cmd_t      cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_QRD    = 4'd1;
  localparam logic [3:0] S_QLAT   = 4'd2;
  localparam logic [3:0] S_DISP   = 4'd3;
  localparam logic [3:0] S_SRD    = 4'd4;
  localparam logic [3:0] S_SWR    = 4'd5;
  localparam logic [3:0] S_STAIL  = 4'd6;
  localparam logic [3:0] S_RCHK   = 4'd7;
  localparam logic [3:0] S_REVAL  = 4'd8;
  localparam logic [3:0] S_RFIN   = 4'd9;
  localparam logic [3:0] S_RPUSH  = 4'd10;
  localparam logic [3:0] S_FCHK   = 4'd11;
  localparam logic [3:0] S_FEVAL  = 4'd12;
  localparam logic [3:0] S_RESP   = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = tmqm_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = tmqm_pkg::OP_LOAD;
          state_next = S_QRD;
        end
      end
      S_QRD:  state_next = S_QLAT;
      S_QLAT: begin
        cmd.op     = tmqm_pkg::OP_QLATCH;
        state_next = S_DISP;
      end
      S_DISP: begin
        if (st.q_bad) begin
          cmd.op     = tmqm_pkg::OP_BAD;
          state_next = S_RESP;
        end else begin
          case (st.mode)
            tmqm_pkg::MODE_SEND: begin
              cmd.op     = tmqm_pkg::OP_SEND_CHK;
              state_next = st.send_ok ? S_SRD : S_RESP;
            end
            tmqm_pkg::MODE_RECV: begin
              cmd.op     = tmqm_pkg::OP_WALK_INIT;
              state_next = S_RCHK;
            end
            tmqm_pkg::MODE_FLUSH: begin
              cmd.op     = tmqm_pkg::OP_WALK_INIT;
              state_next = S_FCHK;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_SRD: begin
        cmd.op     = tmqm_pkg::OP_SEND_RD;
        state_next = S_SWR;
      end
      S_SWR: begin
        cmd.op     = tmqm_pkg::OP_SEND_WR;
        state_next = S_STAIL;
      end
      S_STAIL: begin
        cmd.op     = tmqm_pkg::OP_SEND_TAIL;
        state_next = S_RESP;
      end
      S_RCHK: begin
        if (st.walk_more) begin
          cmd.op     = tmqm_pkg::OP_WALK_RD;
          state_next = S_REVAL;
        end else begin
          state_next = S_RFIN;
        end
      end
      S_REVAL: begin
        cmd.op     = tmqm_pkg::OP_R_EVAL;
        state_next = S_RCHK;
      end
      S_RFIN: begin
        cmd.op     = tmqm_pkg::OP_R_FIN;
        state_next = st.recv_ok ? S_RPUSH : S_RESP;
      end
      S_RPUSH: begin
        cmd.op     = tmqm_pkg::OP_R_PUSH;
        state_next = S_RESP;
      end
      S_FCHK: begin
        if (st.walk_more) begin
          cmd.op     = tmqm_pkg::OP_WALK_RD;
          state_next = S_FEVAL;
        end else begin
          cmd.op     = tmqm_pkg::OP_F_FIN;
          state_next = S_RESP;
        end
      end
      S_FEVAL: begin
        cmd.op     = tmqm_pkg::OP_F_EVAL;
        state_next = S_FCHK;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.op     = tmqm_pkg::OP_RESP;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ src/tmqm_dp.sv @@
// Datapath: slot and queue stores, free stack, list walk and result register.
`timescale 1ns / 1ps
`default_nettype none
module tmqm_dp #(
  parameter int SLOTS  = tmqm_pkg::SLOTS_DEFAULT,
  parameter int QUEUES = tmqm_pkg::QUEUES_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [55:0]    s_tdata,
  input  wire logic           cfg_valid,
  input  wire logic           cfg_index,
  input  wire logic [15:0]    cfg_data,
  output logic [79:0]         m_tdata,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  input  wire tmqm_pkg::cmd_t cmd,
  output tmqm_pkg::stat_t     st
);
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int GW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int BW = tmqm_pkg::BYTES_W;
  localparam int QSW = 2 * LW + CW + BW;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  logic [15:0] byte_limit;
  logic [11:0] max_bytes;

  logic [1:0]         mode_r;
  logic [2:0]         q_r;
  logic signed [31:0] typ_r;
  logic [11:0]        size_r;
  logic               trunc_r;

  logic [LW-1:0] head, tail;
  logic [CW-1:0] cnt;
  logic [BW-1:0] bytes;
  logic [LW-1:0] free_top, cur, prev, hit, hitprev, hit_next;
  logic signed [31:0] hit_type;
  logic [11:0]   hit_size;
  logic [GW-1:0] guard;
  logic          stop;

  logic [2:0]  res_status;
  logic [3:0]  res_slot;
  logic [31:0] res_type;
  logic [11:0] res_len;

  logic [SLOTS-1:0]  lvalid;
  logic [QUEUES-1:0] qvalid;

  // link store
  logic          lwe;
  logic [SW-1:0] lwaddr, lraddr, lraddr_q;
  logic [LW-1:0] lwdata, lram_q, link_rd;
  // type/size store
  logic          twe;
  logic [43:0]   ts_q;
  // queue store
  logic          qwe;
  logic [QSW-1:0] qram_q, qword;
  logic [QW-1:0] qidx;

  assign qidx = QW'(q_r);

  tmqm_ram #(.W(LW), .D(SLOTS)) u_link (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(lraddr), .rdata(lram_q)
  );
  tmqm_ram #(.W(44), .D(SLOTS)) u_ts (
    .clk(clk), .we(twe), .waddr(free_top[SW-1:0]), .wdata({typ_r, size_r}),
    .raddr(cur[SW-1:0]), .rdata(ts_q)
  );
  tmqm_ram #(.W(QSW), .D(QUEUES)) u_q (
    .clk(clk), .we(qwe), .waddr(qidx), .wdata({head, tail, cnt, bytes}),
    .raddr(qidx), .rdata(qram_q)
  );

  // unwritten entries read as their reset value
  assign link_rd = lvalid[lraddr_q] ? lram_q : LW'(lraddr_q) + LW'(1);
  assign qword   = qvalid[qidx] ? qram_q : {NIL, NIL, CW'(0), BW'(0)};

  logic               q_bad;
  logic [2:0]         send_code;
  logic               hit_ok, recv_ok;
  logic signed [31:0] t_rd;
  logic [11:0]        sz_rd;
  logic signed [32:0] mag;

  assign q_bad = {29'd0, q_r} >= 32'(QUEUES);
  assign t_rd  = ts_q[43:12];
  assign sz_rd = ts_q[11:0];
  assign mag   = typ_r[31] ? -{typ_r[31], typ_r} : {typ_r[31], typ_r};
  assign hit_ok  = hit < NIL;
  assign recv_ok = hit_ok && !((size_r < hit_size) && !trunc_r);

  always_comb begin
    if (size_r > max_bytes)                 send_code = tmqm_pkg::ST_INVALID;
    else if (!(free_top < NIL))             send_code = tmqm_pkg::ST_NO_SLOT;
    else if (bytes >= BW'(byte_limit))      send_code = tmqm_pkg::ST_FULL;
    else                                    send_code = tmqm_pkg::ST_OK;
  end

  assign st.mode      = mode_r;
  assign st.q_bad     = q_bad;
  assign st.send_ok   = (send_code == tmqm_pkg::ST_OK);
  assign st.walk_more = (cur < NIL) && (guard < GW'(SLOTS)) && !stop;
  assign st.recv_ok   = recv_ok;
  assign st.out_free  = !m_tvalid || m_tready;

  always_comb begin
    lraddr = cur[SW-1:0];
    if (cmd.op == tmqm_pkg::OP_SEND_RD) lraddr = free_top[SW-1:0];
    lwe    = 1'b0;
    lwaddr = cur[SW-1:0];
    lwdata = free_top;
    twe    = 1'b0;
    qwe    = 1'b0;
    case (cmd.op)
      tmqm_pkg::OP_SEND_WR: begin
        lwe    = 1'b1;
        lwaddr = free_top[SW-1:0];
        lwdata = NIL;
        twe    = 1'b1;
      end
      tmqm_pkg::OP_SEND_TAIL: begin
        lwe    = tail < NIL;
        lwaddr = tail[SW-1:0];
        lwdata = hit;
      end
      tmqm_pkg::OP_R_FIN: begin
        lwe    = recv_ok && (hitprev < NIL);
        lwaddr = hitprev[SW-1:0];
        lwdata = hit_next;
      end
      tmqm_pkg::OP_R_PUSH: begin
        lwe    = 1'b1;
        lwaddr = hit[SW-1:0];
        lwdata = free_top;
      end
      tmqm_pkg::OP_F_EVAL: begin
        lwe    = 1'b1;
        lwaddr = cur[SW-1:0];
        lwdata = free_top;
      end
      tmqm_pkg::OP_RESP: qwe = !q_bad;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= tmqm_pkg::BYTE_LIMIT_RESET;
      max_bytes  <= tmqm_pkg::MAX_BYTES_RESET;
      free_top   <= '0;
      lvalid     <= '0;
      qvalid     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == tmqm_pkg::CFG_BYTE_LIMIT) byte_limit <= cfg_data;
        else                                       max_bytes  <= cfg_data[11:0];
      end
      if (lwe) lvalid[lwaddr] <= 1'b1;
      if (qwe) qvalid[qidx] <= 1'b1;
      case (cmd.op)
        tmqm_pkg::OP_SEND_WR: free_top <= link_rd;
        tmqm_pkg::OP_R_PUSH:  free_top <= hit;
        tmqm_pkg::OP_F_EVAL:  free_top <= cur;
        default: ;
      endcase
      if (cmd.op == tmqm_pkg::OP_RESP) m_tvalid <= 1'b1;
      else if (m_tready)               m_tvalid <= 1'b0;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    lraddr_q <= lraddr;
    case (cmd.op)
      tmqm_pkg::OP_LOAD: begin
        mode_r     <= s_tdata[1:0];
        q_r        <= s_tdata[4:2];
        typ_r      <= s_tdata[36:5];
        size_r     <= s_tdata[48:37];
        trunc_r    <= s_tdata[49];
        res_status <= tmqm_pkg::ST_OK;
        res_slot   <= '0;
        res_type   <= '0;
        res_len    <= '0;
      end
      tmqm_pkg::OP_QLATCH: {head, tail, cnt, bytes} <= qword;
      tmqm_pkg::OP_BAD:      res_status <= tmqm_pkg::ST_INVALID;
      tmqm_pkg::OP_SEND_CHK: res_status <= send_code;
      tmqm_pkg::OP_SEND_WR: begin
        hit      <= free_top;
        res_slot <= 4'(free_top);
      end
      tmqm_pkg::OP_SEND_TAIL: begin
        tail  <= hit;
        if (!(head < NIL)) head <= hit;
        cnt   <= cnt + CW'(1);
        bytes <= bytes + BW'(size_r);
      end
      tmqm_pkg::OP_WALK_INIT: begin
        cur     <= head;
        prev    <= NIL;
        hit     <= NIL;
        hitprev <= NIL;
        guard   <= '0;
        stop    <= 1'b0;
      end
      tmqm_pkg::OP_R_EVAL: begin
        if (typ_r == 32'sd0 || (!typ_r[31] && t_rd == typ_r)) begin
          hit <= cur; hitprev <= prev; hit_type <= t_rd; hit_size <= sz_rd;
          hit_next <= link_rd; stop <= 1'b1;
        end else if (typ_r[31] && ($signed({t_rd[31], t_rd}) <= mag) &&
                     (!hit_ok || t_rd < hit_type)) begin
          hit <= cur; hitprev <= prev; hit_type <= t_rd; hit_size <= sz_rd;
          hit_next <= link_rd;
        end
        prev  <= cur;
        cur   <= link_rd;
        guard <= guard + GW'(1);
      end
      tmqm_pkg::OP_R_FIN: begin
        if (!hit_ok) begin
          res_status <= tmqm_pkg::ST_NO_MATCH;
        end else if (!recv_ok) begin
          res_status <= tmqm_pkg::ST_TOO_BIG;
        end else begin
          if (!(hitprev < NIL)) head <= hit_next;
          if (tail == hit) tail <= hitprev;
          if (cnt != '0) cnt <= cnt - CW'(1);
          bytes    <= (bytes >= BW'(hit_size)) ? bytes - BW'(hit_size) : '0;
          res_len  <= (size_r < hit_size) ? size_r : hit_size;
          res_type <= hit_type;
          res_slot <= 4'(hit);
        end
      end
      tmqm_pkg::OP_F_EVAL: begin
        cur   <= link_rd;
        guard <= guard + GW'(1);
      end
      tmqm_pkg::OP_F_FIN: begin
        head  <= NIL;
        tail  <= NIL;
        cnt   <= '0;
        bytes <= '0;
      end
      tmqm_pkg::OP_RESP: begin
        m_tdata <= {7'd0,
                    q_bad ? 17'd0 : 17'(bytes),
                    q_bad ? 5'd0 : 5'(cnt),
                    res_len, res_type, res_slot, res_status};
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ src/typed_message_queue_manager.sv @@
// Top level: typed message queue manager over a shared slot pool.
`timescale 1ns / 1ps
`default_nettype none
// One request word in, one result word out. Requests are handled one at a
// time; flush and receive walk the messages in the addressed queue (at most
// SLOTS), with one registered read of the slot stores per message. A result
// waiting at the output does not hold up acceptance of the next request;
// that request's result then waits until the output register frees. Config
// writes are always accepted and should be issued only while idle.
module typed_message_queue_manager #(
  parameter int SLOTS  = tmqm_pkg::SLOTS_DEFAULT,
  parameter int QUEUES = tmqm_pkg::QUEUES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // mode[1:0], queue[4:2], type_sel[36:5], size[48:37], allow_truncate[49]
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], slot[6:3], delivered_type[38:7], length[50:39],
  // queue_count[55:51], queue_bytes[72:56]
  output logic [79:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  tmqm_pkg::cmd_t  cmd;
  tmqm_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  tmqm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .st(st), .cmd(cmd)
  );

  tmqm_dp #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cmd(cmd), .st(st)
  );
endmodule
`default_nettype wire

@@ tb/tb_typed_message_queue_manager.sv @@
// Testbench for the typed message queue manager: random and directed requests.
`timescale 1ns / 1ps
`default_nettype none

class tmqm_scoreboard;
  logic [4:0]  link [16];
  logic [31:0] mtype [16];
  logic [11:0] msize [16];
  logic [4:0]  qhead [8];
  logic [4:0]  qtail [8];
  logic [4:0]  qcnt [8];
  logic [16:0] qbytes [8];
  logic [4:0]  free_top;
  logic [15:0] byte_limit;
  logic [11:0] max_bytes;
  logic [79:0] pending [$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
    for (int i = 0; i < 16; i++) begin
      link[i] = 5'(i + 1);
      mtype[i] = '0;
      msize[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      qhead[i] = 5'd16;
      qtail[i] = 5'd16;
      qcnt[i] = '0;
      qbytes[i] = '0;
    end
    free_top = '0;
    byte_limit = tmqm_pkg::BYTE_LIMIT_RESET;
    max_bytes = tmqm_pkg::MAX_BYTES_RESET;
  endfunction

  function void set_reg(logic idx, logic [15:0] val);
    if (idx == tmqm_pkg::CFG_BYTE_LIMIT) byte_limit = val;
    else max_bytes = val[11:0];
  endfunction

  function int depth();
    return pending.size();
  endfunction

  function int free_count();
    int n;
    logic [4:0] c;
    n = 0;
    c = free_top;
    while (c < 16 && n < 16) begin
      n++;
      c = link[c];
    end
    return n;
  endfunction

  // predict one request and queue the expected word
  function void note_request(logic [55:0] w);
    logic [1:0] mode;
    logic [2:0] q;
    logic signed [31:0] typ;
    logic [11:0] sz;
    logic trunc;
    logic [2:0] st;
    logic [3:0] slot;
    logic [31:0] dt;
    logic [11:0] len;
    logic [4:0] cur, prev, hit, hitprev, s, nxt;
    longint mag;
    int guard;
    mode = w[1:0];
    q = w[4:2];
    typ = w[36:5];
    sz = w[48:37];
    trunc = w[49];
    st = tmqm_pkg::ST_OK;
    slot = '0;
    dt = '0;
    len = '0;
    if (mode == tmqm_pkg::MODE_SEND) begin
      if (sz > max_bytes) st = tmqm_pkg::ST_INVALID;
      else if (free_top >= 16) st = tmqm_pkg::ST_NO_SLOT;
      else if (qbytes[q] >= {1'b0, byte_limit}) st = tmqm_pkg::ST_FULL;
      else begin
        s = free_top;
        free_top = link[s];
        mtype[s] = typ;
        msize[s] = sz;
        link[s] = 5'd16;
        if (qtail[q] < 16) link[qtail[q]] = s;
        else qhead[q] = s;
        qtail[q] = s;
        qcnt[q]++;
        qbytes[q] += sz;
        slot = s[3:0];
      end
    end else if (mode == tmqm_pkg::MODE_RECV) begin
      cur = qhead[q];
      prev = 5'd16;
      hit = 5'd16;
      hitprev = 5'd16;
      guard = 0;
      mag = typ < 0 ? -longint'(typ) : longint'(typ);
      while (cur < 16 && guard < 16) begin
        if (typ == 0) begin
          hit = cur; hitprev = prev; break;
        end else if (typ > 0) begin
          if ($signed(mtype[cur]) == typ) begin
            hit = cur; hitprev = prev; break;
          end
        end else if (longint'($signed(mtype[cur])) <= mag &&
                     (hit >= 16 || $signed(mtype[cur]) < $signed(mtype[hit]))) begin
          hit = cur; hitprev = prev;
        end
        prev = cur;
        cur = link[cur];
        guard++;
      end
      if (hit >= 16) st = tmqm_pkg::ST_NO_MATCH;
      else if (sz < msize[hit] && !trunc) st = tmqm_pkg::ST_TOO_BIG;
      else begin
        nxt = link[hit];
        if (hitprev < 16) link[hitprev] = nxt;
        else qhead[q] = nxt;
        if (qtail[q] == hit) qtail[q] = hitprev;
        if (qcnt[q] > 0) qcnt[q]--;
        qbytes[q] = qbytes[q] >= msize[hit] ? qbytes[q] - msize[hit] : '0;
        len = sz < msize[hit] ? sz : msize[hit];
        dt = mtype[hit];
        slot = hit[3:0];
        link[hit] = free_top;
        free_top = hit;
      end
    end else if (mode == tmqm_pkg::MODE_FLUSH) begin
      cur = qhead[q];
      guard = 0;
      while (cur < 16 && guard < 16) begin
        nxt = link[cur];
        link[cur] = free_top;
        free_top = cur;
        cur = nxt;
        guard++;
      end
      qhead[q] = 5'd16;
      qtail[q] = 5'd16;
      qcnt[q] = '0;
      qbytes[q] = '0;
    end
    pending.push_back({7'd0, qbytes[q], qcnt[q], len, dt, slot, st});
  endfunction

  task report(string what, logic [79:0] got, logic [79:0] want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h (word %0d)", what, got, want, checked);
  endtask

  task check_result(logic [79:0] got);
    logic [79:0] want;
    checked++;
    if (pending.size() == 0) begin
      report("unexpected word", got, '0);
      return;
    end
    want = pending.pop_front();
    if (got[2:0] !== want[2:0]) report("status", 80'(got[2:0]), 80'(want[2:0]));
    if (got[6:3] !== want[6:3]) report("slot", 80'(got[6:3]), 80'(want[6:3]));
    if (got[38:7] !== want[38:7])
      report("delivered_type", 80'(got[38:7]), 80'(want[38:7]));
    if (got[50:39] !== want[50:39]) report("length", 80'(got[50:39]), 80'(want[50:39]));
    if (got[55:51] !== want[55:51])
      report("queue_count", 80'(got[55:51]), 80'(want[55:51]));
    if (got[72:56] !== want[72:56])
      report("queue_bytes", 80'(got[72:56]), 80'(want[72:56]));
  endtask
endclass

module tb_typed_message_queue_manager;
  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [55:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [79:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [15:0] cfg_data;

  tmqm_scoreboard board;
  int cycle_count;
  bit no_idle;
  bit hold_off;
  int sent;

  typed_message_queue_manager dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("timeout at cycle %0d", cycle_count);
        $display("tb_typed_message_queue_manager: done, errors");
        $finish;
      end
    end
  end

  // receive side: checks at the rising edge, stalls at the falling edge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
      @(negedge clk);
      if (hold_off) m_tready <= 1'b0;
      else m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  function automatic logic [55:0] pack_req(logic [1:0] mode, logic [2:0] q,
                                           logic [31:0] typ, logic [11:0] sz,
                                           logic tr);
    return {6'd0, tr, sz, typ, q, mode};
  endfunction

  task automatic put_request(logic [55:0] w);
    if (!no_idle)
      while ($urandom_range(99) < 9) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    board.note_request(w);
    sent++;
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (board.depth() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // type drawn from a small set so that typed receives often match
  function automatic logic [31:0] pick_type();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0001;
      2: return $urandom();
      3: return -32'($urandom_range(6));
      default: return 32'($urandom_range(6));
    endcase
  endfunction

  task automatic random_phase(int count, int max_sz);
    logic [1:0] mode;
    logic [31:0] typ;
    logic [11:0] sz;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      // lean on sends so receives find messages
      if (r < 45) mode = tmqm_pkg::MODE_SEND;
      else if (r < 85) mode = tmqm_pkg::MODE_RECV;
      else if (r < 93) mode = tmqm_pkg::MODE_FLUSH;
      else mode = tmqm_pkg::MODE_STATUS;
      typ = pick_type();
      if (mode == tmqm_pkg::MODE_RECV && $urandom_range(3) == 0) typ = '0;
      else if (mode == tmqm_pkg::MODE_RECV && $urandom_range(2) == 0) typ = -$signed(typ);
      sz = ($urandom_range(19) == 0) ? 12'($urandom()) : 12'($urandom_range(max_sz));
      put_request(pack_req(mode, 3'($urandom_range(7)), typ, sz, 1'($urandom())));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = tmqm_pkg::CFG_BYTE_LIMIT;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    sent = 0;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every mode, refused sends and receives
    put_request(pack_req(tmqm_pkg::MODE_RECV, 3'd0, 32'd0, 12'd0, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_SEND, 3'd0, 32'h7fff_ffff, 12'd640, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_SEND, 3'd0, 32'h8000_0001, 12'd0, 1'b1));
    put_request(pack_req(tmqm_pkg::MODE_SEND, 3'd0, 32'd5, 12'd641, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_SEND, 3'd7, 32'd3, 12'd100, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_SEND, 3'd7, 32'd2, 12'd200, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_SEND, 3'd7, 32'd2, 12'd300, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_RECV, 3'd7, 32'd2, 12'd100, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_RECV, 3'd7, 32'd2, 12'd100, 1'b1));
    put_request(pack_req(tmqm_pkg::MODE_RECV, 3'd7, 32'd9, 12'd4095, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_RECV, 3'd7, -32'sd3, 12'd4095, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_RECV, 3'd0, 32'h8000_0001, 12'd4095, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_STATUS, 3'd7, 32'hffff_ffff, 12'hfff, 1'b1));
    put_request(pack_req(tmqm_pkg::MODE_FLUSH, 3'd0, 32'd0, 12'd0, 1'b0));
    drain();

    // hit the byte limit, then exhaust the pool
    write_reg(tmqm_pkg::CFG_MAX_BYTES, 16'd4095);
    write_reg(tmqm_pkg::CFG_BYTE_LIMIT, 16'd0);
    put_request(pack_req(tmqm_pkg::MODE_SEND, 3'd1, 32'd1, 12'd10, 1'b0));
    drain();
    write_reg(tmqm_pkg::CFG_BYTE_LIMIT, 16'hffff);
    for (int i = 0; i < 17; i++)
      put_request(pack_req(tmqm_pkg::MODE_SEND, 3'(i % 3), 32'(i), 12'd4095, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_FLUSH, 3'd1, 32'd0, 12'd0, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_FLUSH, 3'd0, 32'd0, 12'd0, 1'b0));
    put_request(pack_req(tmqm_pkg::MODE_FLUSH, 3'd2, 32'd0, 12'd0, 1'b0));
    drain();

    write_reg(tmqm_pkg::CFG_BYTE_LIMIT, 16'd300);
    write_reg(tmqm_pkg::CFG_MAX_BYTES, 16'd200);
    random_phase(130, 220);
    drain();

    // receiver held off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(20, 220);
    join
    drain();

    write_reg(tmqm_pkg::CFG_BYTE_LIMIT, 16'd2048);
    write_reg(tmqm_pkg::CFG_MAX_BYTES, 16'd0);
    random_phase(40, 3);
    drain();

    write_reg(tmqm_pkg::CFG_BYTE_LIMIT, 16'd1500);
    write_reg(tmqm_pkg::CFG_MAX_BYTES, 16'd640);
    no_idle = 1'b1;
    random_phase(80, 700);
    no_idle = 1'b0;
    random_phase(110, 700);
    drain();

    $display("covered %0d requests over several register settings, %0d slots free at end",
             sent, board.free_count());
    $display("pool exhaustion, byte limit, typed/lowest receives, truncation, flush, stall");
    if (board.errors == 0 && board.depth() == 0)
      $display("tb_typed_message_queue_manager: done, clean");
    else
      $display("tb_typed_message_queue_manager: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
